@@ hdl/dssg_pkg.sv @@
// Shared types, codes and index helpers for the digital strip scan generator.
// No dependencies; imported by every module of the block.
package dssg_pkg;

    localparam int DSSG_COORD_BITS = 16;
    localparam int DSSG_IDX_BITS   = 6;
    localparam int DSSG_PER_BITS   = 7;
    localparam int DSSG_MAX_STEPS  = 64;
    localparam int DSSG_MAX_SCAN   = 64;
    localparam int DSSG_FIFO_DEPTH = 2;
    localparam int DSSG_CFG_IDX_BITS  = 3;
    localparam int DSSG_CFG_DATA_BITS = 64;

    // input item modes
    localparam logic [1:0] MODE_START = 2'd0;
    localparam logic [1:0] MODE_FIRST = 2'd1;
    localparam logic [1:0] MODE_LEFT  = 2'd2;
    localparam logic [1:0] MODE_RIGHT = 2'd3;

    // configuration register indexes
    localparam logic [DSSG_CFG_IDX_BITS-1:0] CFG_LINE_A      = 3'd0;
    localparam logic [DSSG_CFG_IDX_BITS-1:0] CFG_LINE_B      = 3'd1;
    localparam logic [DSSG_CFG_IDX_BITS-1:0] CFG_UPPER_BOUND = 3'd2;
    localparam logic [DSSG_CFG_IDX_BITS-1:0] CFG_CLIP_X_LOW  = 3'd3;
    localparam logic [DSSG_CFG_IDX_BITS-1:0] CFG_CLIP_Y_LOW  = 3'd4;
    localparam logic [DSSG_CFG_IDX_BITS-1:0] CFG_CLIP_X_HIGH = 3'd5;
    localparam logic [DSSG_CFG_IDX_BITS-1:0] CFG_CLIP_Y_HIGH = 3'd6;
    localparam logic [DSSG_CFG_IDX_BITS-1:0] CFG_STEP_PATTERN = 3'd7;

    typedef logic signed [DSSG_COORD_BITS-1:0] t_coord;
    typedef logic [DSSG_IDX_BITS-1:0]          t_idx;
    typedef logic [DSSG_PER_BITS-1:0]          t_per;

    typedef struct packed {
        logic signed [15:0] line_a;
        logic signed [15:0] line_b;
        logic signed [31:0] upper_bound;
        logic signed [15:0] clip_x_low;
        logic signed [15:0] clip_y_low;
        logic signed [15:0] clip_x_high;
        logic signed [15:0] clip_y_high;
        logic [63:0]        step_pattern;
    } t_cfg;

    // one unit of work for the walker: a start acknowledgment or a scan
    typedef struct packed {
        logic   is_start;
        t_coord x;
        t_coord y;
        t_idx   idx;
        t_per   per;
    } t_cmd;

    function automatic t_idx idx_inc(input t_idx i, input t_per per);
        t_per nxt;
        nxt = DSSG_PER_BITS'(i) + DSSG_PER_BITS'(1);
        return (nxt >= per) ? '0 : nxt[DSSG_IDX_BITS-1:0];
    endfunction

    function automatic t_idx idx_dec(input t_idx i, input t_per per);
        t_per last;
        last = per - DSSG_PER_BITS'(1);
        if (i == '0 || DSSG_PER_BITS'(i) >= per) begin
            return last[DSSG_IDX_BITS-1:0];
        end
        return i - DSSG_IDX_BITS'(1);
    endfunction

    function automatic logic pbit(input logic [63:0] pattern, input t_idx i);
        return pattern[i];
    endfunction

endpackage

@@ hdl/dssg_front.sv @@
// Front end: accepts input items, keeps the left/right scan origins and
// turns each item into a walker command. Depends on dssg_pkg.
module dssg_front import dssg_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_push,
    input  logic [1:0]  i_mode,
    input  t_coord      i_origin_x,
    input  t_coord      i_origin_y,
    input  t_per        i_pattern_length,
    input  logic [63:0] i_step_pattern,
    output t_cmd        o_cmd
);

    t_coord r_lx, r_ly, r_rx, r_ry;
    t_coord n_lx, n_ly, n_rx, n_ry;
    t_idx   r_lb, r_ls, r_rb, r_rs;
    t_idx   n_lb, n_ls, n_rb, n_rs;
    logic   r_lhold, r_rhold, n_lhold, n_rhold;
    t_per   r_per, n_per;

    t_per   c_len;
    t_idx   c_lb_dec;
    t_idx   c_rs_dec;

    always_comb begin
        c_len    = i_pattern_length;
        if (c_len == '0) begin
            c_len = DSSG_PER_BITS'(1);
        end else if (c_len > DSSG_PER_BITS'(DSSG_MAX_STEPS)) begin
            c_len = DSSG_PER_BITS'(DSSG_MAX_STEPS);
        end
        c_lb_dec = idx_dec(r_lb, r_per);
        c_rs_dec = idx_dec(r_rs, r_per);

        n_lx = r_lx; n_ly = r_ly; n_rx = r_rx; n_ry = r_ry;
        n_lb = r_lb; n_ls = r_ls; n_rb = r_rb; n_rs = r_rs;
        n_lhold = r_lhold; n_rhold = r_rhold; n_per = r_per;

        case (i_mode)
            MODE_START: begin
                n_lx = i_origin_x; n_ly = i_origin_y;
                n_rx = i_origin_x; n_ry = i_origin_y;
                n_lb = '0; n_ls = '0; n_rb = '0; n_rs = '0;
                n_lhold = 1'b0; n_rhold = 1'b0;
                n_per = c_len;
            end
            MODE_FIRST: begin
            end
            MODE_LEFT: begin
                n_lx = r_lx - DSSG_COORD_BITS'(1);
                if (r_lhold) begin
                    n_lhold = 1'b0;
                end else begin
                    n_lb = c_lb_dec;
                    if (pbit(i_step_pattern, c_lb_dec)) begin
                        n_ly = r_ly + DSSG_COORD_BITS'(1);
                        // a pattern transition: make this a pure y move
                        if (pbit(i_step_pattern, r_ls)) begin
                            n_lx    = r_lx;
                            n_lhold = 1'b1;
                        end
                        n_ls = idx_inc(r_ls, r_per);
                    end
                end
            end
            MODE_RIGHT: begin
                if (r_rhold) begin
                    n_ry    = r_ry - DSSG_COORD_BITS'(1);
                    n_rs    = c_rs_dec;
                    n_rhold = 1'b0;
                end else begin
                    n_rx = r_rx + DSSG_COORD_BITS'(1);
                    if (pbit(i_step_pattern, r_rb)) begin
                        if (pbit(i_step_pattern, c_rs_dec)) begin
                            n_rs    = idx_inc(c_rs_dec, r_per);
                            n_rhold = 1'b1;
                        end else begin
                            n_rs = c_rs_dec;
                            n_ry = r_ry - DSSG_COORD_BITS'(1);
                        end
                    end
                    n_rb = idx_inc(r_rb, r_per);
                end
            end
            default: begin
            end
        endcase

        o_cmd.is_start = (i_mode == MODE_START);
        o_cmd.per      = n_per;
        if (i_mode == MODE_RIGHT) begin
            o_cmd.x   = n_rx;
            o_cmd.y   = n_ry;
            o_cmd.idx = n_rs;
        end else begin
            o_cmd.x   = n_lx;
            o_cmd.y   = n_ly;
            o_cmd.idx = n_ls;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_lx <= '0; r_ly <= '0; r_rx <= '0; r_ry <= '0;
            r_lb <= '0; r_ls <= '0; r_rb <= '0; r_rs <= '0;
            r_lhold <= 1'b0; r_rhold <= 1'b0;
            r_per <= DSSG_PER_BITS'(1);
        end else if (i_push) begin
            r_lx <= n_lx; r_ly <= n_ly; r_rx <= n_rx; r_ry <= n_ry;
            r_lb <= n_lb; r_ls <= n_ls; r_rb <= n_rb; r_rs <= n_rs;
            r_lhold <= n_lhold; r_rhold <= n_rhold;
            r_per <= n_per;
        end
    end

endmodule

@@ hdl/dssg_fifo.sv @@
// Short command queue between the front end and the walker.
// Depends on dssg_pkg.
module dssg_fifo import dssg_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_cmd i_cmd,
    output logic o_full,
    input  logic i_pop,
    output logic o_empty,
    output t_cmd o_cmd
);

    localparam int PTR_W = (DSSG_FIFO_DEPTH > 1) ? $clog2(DSSG_FIFO_DEPTH) : 1;
    localparam int CNT_W = $clog2(DSSG_FIFO_DEPTH + 1);

    t_cmd             r_mem [DSSG_FIFO_DEPTH];
    logic [PTR_W-1:0] r_wr_ptr, r_rd_ptr, n_wr_ptr, n_rd_ptr;
    logic [CNT_W-1:0] r_count, n_count;

    assign o_full  = (r_count == CNT_W'(DSSG_FIFO_DEPTH));
    assign o_empty = (r_count == '0);
    assign o_cmd   = r_mem[r_rd_ptr];

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (i_push) begin
            n_wr_ptr = (r_wr_ptr == PTR_W'(DSSG_FIFO_DEPTH - 1)) ? '0
                                                              : r_wr_ptr + PTR_W'(1);
        end
        if (i_pop) begin
            n_rd_ptr = (r_rd_ptr == PTR_W'(DSSG_FIFO_DEPTH - 1)) ? '0
                                                              : r_rd_ptr + PTR_W'(1);
        end
        if (i_push && !i_pop) begin
            n_count = r_count + CNT_W'(1);
        end else if (!i_push && i_pop) begin
            n_count = r_count - CNT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

endmodule

@@ hdl/dssg_walker.sv @@
// Back end: walks one scan a pixel per cycle, first to count and detect truncation,
// then to deliver the pixels, waiting while the output is stalled. Depends on dssg_pkg.
module dssg_walker import dssg_pkg::*; #(
    parameter int MAX_SCAN = DSSG_MAX_SCAN
) (
    input  logic   i_clk,
    input  logic   i_rst_n,
    input  t_cfg   i_cfg,
    input  logic   i_cmd_valid,
    input  t_cmd   i_cmd,
    output logic   o_pop,
    output logic   o_out_valid,
    input  logic   i_out_ready,
    output t_coord o_pixel_x,
    output t_coord o_pixel_y,
    output logic   o_pixel_valid,
    output logic   o_last,
    output logic   o_truncated
);

    localparam int XW    = DSSG_COORD_BITS + 1;
    localparam int PW    = XW + 16;
    localparam int VW    = PW + 1;
    localparam int CNT_W = $clog2(MAX_SCAN + 1);

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_MUL  = 3'd1;
    localparam logic [2:0] ST_SUM  = 3'd2;
    localparam logic [2:0] ST_SKIP = 3'd3;
    localparam logic [2:0] ST_SCAN = 3'd4;
    localparam logic [2:0] ST_EMIT = 3'd5;

    logic [2:0]           r_state, n_state;
    logic signed [XW-1:0] r_x, r_y, r_x0, r_y0, n_x, n_y, n_x0, n_y0;
    t_idx                 r_idx, r_idx0, n_idx, n_idx0;
    t_per                 r_per, n_per;
    logic signed [PW-1:0] r_pa, r_pb, n_pa, n_pb;
    logic signed [16:0]   r_ab, n_ab;
    logic signed [VW-1:0] r_v, n_v;
    logic [CNT_W-1:0]     r_n, r_k, n_n, n_k;
    logic                 r_tr, n_tr;
    logic                 r_ov, n_ov;
    t_coord               r_px, r_py, n_px, n_py;
    logic                 r_pv, r_last, r_trunc, n_pv, n_last, n_trunc;

    logic                 c_pbit, c_under, c_hi_ok, c_lo_ok, c_free, c_is_last;
    logic signed [XW-1:0] c_sx, c_sy;
    t_idx                 c_sidx;
    logic signed [VW-1:0] c_sv;

    always_comb begin
        c_pbit  = pbit(i_cfg.step_pattern, r_idx);
        c_sx    = c_pbit ? r_x + XW'(1) : r_x;
        c_sy    = r_y + XW'(1);
        c_sidx  = idx_inc(r_idx, r_per);
        c_sv    = r_v + (c_pbit ? VW'(r_ab) : VW'(i_cfg.line_b));
        c_under = (r_v <= VW'(i_cfg.upper_bound));
        c_hi_ok = (r_x < XW'(i_cfg.clip_x_high)) && (r_y < XW'(i_cfg.clip_y_high));
        c_lo_ok = (r_x >= XW'(i_cfg.clip_x_low)) && (r_y >= XW'(i_cfg.clip_y_low));
        c_free  = !r_ov || i_out_ready;
        c_is_last = ((r_k + CNT_W'(1)) == r_n);

        n_state = r_state;
        n_x = r_x; n_y = r_y; n_idx = r_idx; n_per = r_per;
        n_x0 = r_x0; n_y0 = r_y0; n_idx0 = r_idx0;
        n_pa = r_pa; n_pb = r_pb; n_ab = r_ab; n_v = r_v;
        n_n = r_n; n_k = r_k; n_tr = r_tr;
        n_ov = r_ov && !i_out_ready;
        n_px = r_px; n_py = r_py; n_pv = r_pv; n_last = r_last; n_trunc = r_trunc;
        o_pop = 1'b0;

        case (r_state)
            ST_IDLE: begin
                if (i_cmd_valid) begin
                    if (i_cmd.is_start) begin
                        if (c_free) begin
                            o_pop = 1'b1;
                            n_ov = 1'b1; n_px = '0; n_py = '0;
                            n_pv = 1'b0; n_last = 1'b1; n_trunc = 1'b0;
                        end
                    end else begin
                        o_pop   = 1'b1;
                        n_x     = XW'(i_cmd.x);
                        n_y     = XW'(i_cmd.y);
                        n_idx   = i_cmd.idx;
                        n_per   = i_cmd.per;
                        n_state = ST_MUL;
                    end
                end
            end
            ST_MUL: begin
                n_pa    = PW'(i_cfg.line_a) * PW'(r_x);
                n_pb    = PW'(i_cfg.line_b) * PW'(r_y);
                n_ab    = 17'(i_cfg.line_a) + 17'(i_cfg.line_b);
                n_state = ST_SUM;
            end
            ST_SUM: begin
                n_v     = VW'(r_pa) + VW'(r_pb);
                n_state = ST_SKIP;
            end
            ST_SKIP: begin
                // advance past pixels below or left of the window
                if (!c_lo_ok && c_hi_ok && c_under) begin
                    n_x = c_sx; n_y = c_sy; n_idx = c_sidx; n_v = c_sv;
                end else begin
                    n_x0 = r_x; n_y0 = r_y; n_idx0 = r_idx;
                    n_n = '0; n_tr = 1'b0;
                    n_state = ST_SCAN;
                end
            end
            ST_SCAN: begin
                if (c_under && c_hi_ok && c_lo_ok && (r_n != CNT_W'(MAX_SCAN))) begin
                    n_n = r_n + CNT_W'(1);
                    n_x = c_sx; n_y = c_sy; n_idx = c_sidx; n_v = c_sv;
                end else begin
                    n_tr = c_under && c_hi_ok && c_lo_ok;
                    // rewind to the first emitted pixel for the delivery pass
                    n_x = r_x0; n_y = r_y0; n_idx = r_idx0;
                    n_k = '0;
                    n_state = ST_EMIT;
                end
            end
            ST_EMIT: begin
                if (c_free) begin
                    n_ov = 1'b1;
                    if (r_n == '0) begin
                        n_px = '0; n_py = '0;
                        n_pv = 1'b0; n_last = 1'b1; n_trunc = 1'b0;
                        n_state = ST_IDLE;
                    end else begin
                        n_px = r_x[DSSG_COORD_BITS-1:0];
                        n_py = r_y[DSSG_COORD_BITS-1:0];
                        n_pv = 1'b1; n_last = c_is_last; n_trunc = r_tr;
                        n_x = c_sx; n_y = c_sy; n_idx = c_sidx;
                        n_k = r_k + CNT_W'(1);
                        if (c_is_last) begin
                            n_state = ST_IDLE;
                        end
                    end
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_x <= n_x; r_y <= n_y; r_idx <= n_idx; r_per <= n_per;
        r_x0 <= n_x0; r_y0 <= n_y0; r_idx0 <= n_idx0;
        r_pa <= n_pa; r_pb <= n_pb; r_ab <= n_ab; r_v <= n_v;
        r_n <= n_n; r_k <= n_k; r_tr <= n_tr;
        r_px <= n_px; r_py <= n_py; r_pv <= n_pv; r_last <= n_last; r_trunc <= n_trunc;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_ov    <= 1'b0;
        end else begin
            r_state <= n_state;
            r_ov    <= n_ov;
        end
    end

    assign o_out_valid   = r_ov;
    assign o_pixel_x     = r_px;
    assign o_pixel_y     = r_py;
    assign o_pixel_valid = r_pv;
    assign o_last        = r_last;
    assign o_truncated   = r_trunc;

endmodule

@@ hdl/digital_strip_scan_generator_unit.sv @@
// Start item: its one result reaches the output register through the queue and walker.
// Scan item: the walker computes the start value, skips the prefix steps left of or below
// the window, counts the scan's pixels, then delivers one pixel a cycle while the output
// is not stalled. The front end takes an item each cycle while the two-entry queue
// has room. Synchronous active-low reset returns configuration to its
// reset values, both origins to zero, and the queue and the walker to empty.
module digital_strip_scan_generator_unit import dssg_pkg::*; #(
    parameter int MAX_SCAN = DSSG_MAX_SCAN
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_we,
    input  logic [DSSG_CFG_IDX_BITS-1:0]  i_cfg_idx,
    input  logic [DSSG_CFG_DATA_BITS-1:0] i_cfg_data,
    input  logic                          i_in_valid,
    output logic                          o_in_ready,
    input  logic [1:0]                    i_mode,
    input  logic signed [15:0]            i_origin_x,
    input  logic signed [15:0]            i_origin_y,
    input  logic [6:0]                    i_pattern_length,
    output logic                          o_out_valid,
    input  logic                          i_out_ready,
    output logic signed [15:0]            o_pixel_x,
    output logic signed [15:0]            o_pixel_y,
    output logic                          o_pixel_valid,
    output logic                          o_last,
    output logic                          o_truncated
);

    t_cfg r_cfg, n_cfg;
    logic w_push, w_full, w_empty, w_pop;
    t_cmd w_cmd_in, w_cmd_out;

    always_comb begin
        n_cfg = r_cfg;
        if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_LINE_A:       n_cfg.line_a       = i_cfg_data[15:0];
                CFG_LINE_B:       n_cfg.line_b       = i_cfg_data[15:0];
                CFG_UPPER_BOUND:  n_cfg.upper_bound  = i_cfg_data[31:0];
                CFG_CLIP_X_LOW:   n_cfg.clip_x_low   = i_cfg_data[15:0];
                CFG_CLIP_Y_LOW:   n_cfg.clip_y_low   = i_cfg_data[15:0];
                CFG_CLIP_X_HIGH:  n_cfg.clip_x_high  = i_cfg_data[15:0];
                CFG_CLIP_Y_HIGH:  n_cfg.clip_y_high  = i_cfg_data[15:0];
                CFG_STEP_PATTERN: n_cfg.step_pattern = i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= t_cfg'{line_b: 16'sd1, default: '0};
        end else begin
            r_cfg <= n_cfg;
        end
    end

    assign o_in_ready = !w_full;
    assign w_push     = i_in_valid && !w_full;

    dssg_front u_front (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_push           (w_push),
        .i_mode           (i_mode),
        .i_origin_x       (i_origin_x),
        .i_origin_y       (i_origin_y),
        .i_pattern_length (i_pattern_length),
        .i_step_pattern   (r_cfg.step_pattern),
        .o_cmd            (w_cmd_in)
    );

    dssg_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_cmd   (w_cmd_in),
        .o_full  (w_full),
        .i_pop   (w_pop),
        .o_empty (w_empty),
        .o_cmd   (w_cmd_out)
    );

    dssg_walker #(
        .MAX_SCAN (MAX_SCAN)
    ) u_walker (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg         (r_cfg),
        .i_cmd_valid   (!w_empty),
        .i_cmd         (w_cmd_out),
        .o_pop         (w_pop),
        .o_out_valid   (o_out_valid),
        .i_out_ready   (i_out_ready),
        .o_pixel_x     (o_pixel_x),
        .o_pixel_y     (o_pixel_y),
        .o_pixel_valid (o_pixel_valid),
        .o_last        (o_last),
        .o_truncated   (o_truncated)
    );

`ifndef SYNTHESIS
    a_empty_is_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_pixel_valid |-> o_last)
        else $error("result without pixel not marked last");

    a_trunc_has_pixel: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_truncated |-> o_pixel_valid)
        else $error("truncated flag on a result without pixel");

    a_period_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_push |-> (w_cmd_in.per != '0) &&
                   (w_cmd_in.per <= DSSG_PER_BITS'(DSSG_MAX_STEPS)))
        else $error("pattern period out of range");

    a_no_pop_when_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_pop |-> !w_empty)
        else $error("walker took a command from an empty queue");
`endif

endmodule
